[rtl/core/egsb_pkg.sv]
// Shared constants, types and helpers of the epsilon-greedy subset bandit.
package egsb_pkg;

    localparam int MAX_ARMS   = 64;
    localparam int MAX_PICKS  = 16;
    localparam int ARM_W      = 6;
    localparam int ARM_CNT_W  = 7;
    localparam int PICK_W     = 5;
    localparam int PICK_IDX_W = 4;
    localparam int DRAW_W     = 11;
    localparam int MEAN_W     = 32;
    localparam int PULL_W     = 16;
    localparam int DIV_W      = 49;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [DRAW_W-1:0]     DRAW_LIMIT   = 11'd1024;
    localparam logic [31:0]           LFSR_MASK    = 32'h8020_0003;
    localparam logic [ARM_CNT_W-1:0]  ARM_COUNT_RST = 7'd64;
    localparam logic [15:0]           THRESH_RST   = 16'd13107;
    localparam logic [PICK_W-1:0]     PICKS_RST    = 5'd4;
    localparam logic [31:0]           SEED_RST     = 32'd1;
    localparam logic [PULL_W-1:0]     PULL_MAX     = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARM_COUNT = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_PICKS     = 2'd2,
        CFG_SEED      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [PULL_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quotient;
        logic [PULL_W-1:0]    remainder;
    } div_rsp_t;

    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        logic [31:0] s;
        s = {1'b0, v[31:1]};
        if (v[0])
        begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

endpackage

[rtl/core/egsb_if.sv]
// Valid/ready channel interfaces for the bandit's input and result words.
interface egsb_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic signed [31:0] reward;

    modport source (output valid, output kind, output reward, input ready);
    modport sink   (input valid, input kind, input reward, output ready);
endinterface

interface egsb_out_if;
    logic                        valid;
    logic                        ready;
    logic [egsb_pkg::ARM_W-1:0]  arm;
    logic                        last;
    logic                        is_ack;

    modport source (output valid, output arm, output last, output is_ack, input ready);
    modport sink   (input valid, input arm, input last, input is_ack, output ready);
endinterface

[rtl/core/egsb_divider.sv]
// Serial restoring divider, one quotient bit per cycle; shared by modulo and mean update.
module egsb_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  egsb_pkg::div_req_t  req,
    output egsb_pkg::div_rsp_t  rsp
);

    logic                              run_reg;
    logic                              done_reg;
    logic [egsb_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [egsb_pkg::DIV_W-1:0]        quo_reg;
    logic [egsb_pkg::PULL_W-1:0]       rem_reg;
    logic [egsb_pkg::PULL_W-1:0]       den_reg;
    logic [egsb_pkg::PULL_W:0]         shifted;
    logic [egsb_pkg::PULL_W:0]         trial;

    assign shifted = {rem_reg, quo_reg[egsb_pkg::DIV_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == egsb_pkg::DIV_CNT_W'(egsb_pkg::DIV_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[egsb_pkg::DIV_W-2:0], ~trial[egsb_pkg::PULL_W]};
            rem_reg <= trial[egsb_pkg::PULL_W] ? shifted[egsb_pkg::PULL_W-1:0]
                                               : trial[egsb_pkg::PULL_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (den_reg != '0))
        else $error("divider running with zero divisor");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !run_reg)
        else $error("divider restarted while busy");
`endif

endmodule

[rtl/core/epsilon_greedy_subset_bandit_top.sv]
// Top level: sequencer, arm statistics, random generator and result register.
// Usage
//   item   : input words; kind 0 selects a set of arms, kind 1 applies reward.
//   result : one word per chosen arm for a select (last on the final one),
//            one acknowledge word (is_ack, last, arm 0) for an update.
//   cfg_*  : write port; arm_count, explore_threshold, picks_per_select,
//            random_seed (writing the seed reloads the generator).
// Throughput: one word at a time; item.ready is high only while idle.
//   Select: a best-mean scan over n arms, then per draw an exploit pick of
//   the best arm or an explore pick (32-bit modulo on the serial divider),
//   up to 1024 draws, a fill pass over up to n arms, then the result words.
//   Update: per stored arm a read, a multiply, and a 49-bit division on the
//   serial divider for the new mean, then the acknowledge word.
// Reset: statistics read as zero (per-arm valid flags), generator holds seed.
// A stalled receiver holds the result register; the sequencer waits on it,
// but a new item can be taken while the last word of the previous one waits.
module epsilon_greedy_subset_bandit_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [egsb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [egsb_pkg::CFG_DATA_W-1:0]     cfg_data,
    egsb_in_if.sink                             item,
    egsb_out_if.source                          result
);

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_ARGMAX    = 13'b0000000000010,
        ST_DRAW      = 13'b0000000000100,
        ST_EXPLORE   = 13'b0000000001000,
        ST_MOD_WAIT  = 13'b0000000010000,
        ST_CHECK     = 13'b0000000100000,
        ST_FILL      = 13'b0000001000000,
        ST_EMIT      = 13'b0000010000000,
        ST_UPD_READ  = 13'b0000100000000,
        ST_UPD_MUL   = 13'b0001000000000,
        ST_UPD_START = 13'b0010000000000,
        ST_UPD_DIV   = 13'b0100000000000,
        ST_ACK       = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [egsb_pkg::ARM_CNT_W-1:0]  arm_count_reg;
    logic [15:0]                     thresh_reg;
    logic [egsb_pkg::PICK_W-1:0]     picks_reg;
    logic [31:0]                     lfsr_reg, lfsr_next;

    logic [egsb_pkg::ARM_CNT_W-1:0]  n_reg, n_next;
    logic [egsb_pkg::PICK_W-1:0]     want_reg, want_next;
    logic [egsb_pkg::PICK_W-1:0]     got_reg, got_next;
    logic [egsb_pkg::DRAW_W-1:0]     draws_reg, draws_next;
    logic [egsb_pkg::ARM_CNT_W-1:0]  scan_reg, scan_next;
    logic [egsb_pkg::ARM_W-1:0]      best_reg, best_next;
    logic signed [31:0]              best_val_reg, best_val_next;
    logic [egsb_pkg::ARM_W-1:0]      cand_reg, cand_next;
    logic [egsb_pkg::ARM_CNT_W-1:0]  fill_reg, fill_next;
    logic [egsb_pkg::PICK_W-1:0]     idx_reg, idx_next;
    logic [egsb_pkg::PICK_W-1:0]     count_reg, count_next;
    logic signed [31:0]              reward_reg;
    logic signed [48:0]              prod_reg;
    logic [egsb_pkg::PULL_W-1:0]     c_reg;
    logic                            neg_reg;

    logic                            out_valid_reg, out_valid_next;
    logic [egsb_pkg::ARM_W-1:0]      out_arm_reg, out_arm_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_ack_reg, out_ack_next;

    logic [egsb_pkg::ARM_W-1:0]      chosen_reg [egsb_pkg::MAX_PICKS];
    logic                            chosen_we;
    logic [egsb_pkg::ARM_W-1:0]      chosen_wd;

    logic [egsb_pkg::MEAN_W-1:0]     mean_mem  [egsb_pkg::MAX_ARMS];
    logic [egsb_pkg::PULL_W-1:0]     pulls_mem [egsb_pkg::MAX_ARMS];
    logic [egsb_pkg::MAX_ARMS-1:0]   vld_reg;
    logic [egsb_pkg::MEAN_W-1:0]     rd_mean_reg;
    logic [egsb_pkg::PULL_W-1:0]     rd_pulls_reg;
    logic                            rd_vld_reg;
    logic [egsb_pkg::ARM_W-1:0]      rd_addr;
    logic signed [31:0]              mean_eff;
    logic [egsb_pkg::PULL_W-1:0]     pulls_eff;
    logic                            mem_we;
    logic [egsb_pkg::ARM_W-1:0]      upd_arm;
    logic [egsb_pkg::MEAN_W-1:0]     mean_wd;

    logic [egsb_pkg::ARM_CNT_W-1:0]  n_sel;
    logic [egsb_pkg::PICK_W-1:0]     want_sel;
    logic [egsb_pkg::ARM_W-1:0]      chk_arm;
    logic                            hit;
    logic                            out_free;
    logic                            upd_load;
    logic [31:0]                     lfsr_adv;
    logic [egsb_pkg::PULL_W-1:0]     c_new;
    logic signed [48:0]              num;
    logic [48:0]                     mag;
    logic [egsb_pkg::DIV_W-1:0]      quo_signed;

    egsb_pkg::div_req_t              div_req;
    egsb_pkg::div_rsp_t              div_rsp;

    egsb_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign lfsr_adv  = egsb_pkg::lfsr_step(lfsr_reg);
    assign out_free  = !out_valid_reg || result.ready;
    assign upd_arm   = chosen_reg[idx_reg[egsb_pkg::PICK_IDX_W-1:0]];
    assign rd_addr   = (state_reg == ST_ARGMAX) ? scan_reg[egsb_pkg::ARM_W-1:0] : upd_arm;
    assign mean_eff  = rd_vld_reg ? $signed(rd_mean_reg) : 32'sd0;
    assign pulls_eff = rd_vld_reg ? rd_pulls_reg : '0;
    assign c_new     = (pulls_eff == egsb_pkg::PULL_MAX) ? pulls_eff : pulls_eff + 1'b1;
    assign num       = prod_reg + 49'(reward_reg);
    assign mag       = num[48] ? 49'(-num) : 49'(num);
    assign quo_signed = neg_reg ? 49'(-div_rsp.quotient) : div_rsp.quotient;
    assign mean_wd   = quo_signed[31:0];
    assign chk_arm   = (state_reg == ST_FILL) ? fill_reg[egsb_pkg::ARM_W-1:0] : cand_reg;

    always_comb
    begin
        n_sel = arm_count_reg;
        if (arm_count_reg == '0)
        begin
            n_sel = 7'd1;
        end
        else if (arm_count_reg > egsb_pkg::ARM_CNT_W'(egsb_pkg::MAX_ARMS))
        begin
            n_sel = egsb_pkg::ARM_CNT_W'(egsb_pkg::MAX_ARMS);
        end
        want_sel = picks_reg;
        if (picks_reg == '0)
        begin
            want_sel = 5'd1;
        end
        else if (picks_reg > egsb_pkg::PICK_W'(egsb_pkg::MAX_PICKS))
        begin
            want_sel = egsb_pkg::PICK_W'(egsb_pkg::MAX_PICKS);
        end
        if ({2'b00, want_sel} > n_sel)
        begin
            want_sel = n_sel[egsb_pkg::PICK_W-1:0];
        end
    end

    always_comb
    begin
        hit = 1'b0;
        for (int j = 0; j < egsb_pkg::MAX_PICKS; j++)
        begin
            if ((egsb_pkg::PICK_W'(j) < got_reg) && (chosen_reg[j] == chk_arm))
            begin
                hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        lfsr_next      = lfsr_reg;
        n_next         = n_reg;
        want_next      = want_reg;
        got_next       = got_reg;
        draws_next     = draws_reg;
        scan_next      = scan_reg;
        best_next      = best_reg;
        best_val_next  = best_val_reg;
        cand_next      = cand_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_arm_next   = out_arm_reg;
        out_last_next  = out_last_reg;
        out_ack_next   = out_ack_reg;
        chosen_we      = 1'b0;
        chosen_wd      = chk_arm;
        mem_we         = 1'b0;
        upd_load       = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {17'd0, lfsr_adv};
        div_req.divisor  = {9'd0, n_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    idx_next = '0;
                    if (!item.kind)
                    begin
                        n_next     = n_sel;
                        want_next  = want_sel;
                        got_next   = '0;
                        draws_next = '0;
                        scan_next  = '0;
                        state_next = ST_ARGMAX;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_ACK;
                    end
                    else
                    begin
                        state_next = ST_UPD_READ;
                    end
                end
            end
            ST_ARGMAX:
            begin
                if (scan_reg != '0)
                begin
                    if ((scan_reg == 7'd1) || (mean_eff > best_val_reg))
                    begin
                        best_next     = egsb_pkg::ARM_W'(scan_reg - 1'b1);
                        best_val_next = mean_eff;
                    end
                end
                if (scan_reg == n_reg)
                begin
                    state_next = ST_DRAW;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_DRAW:
            begin
                if (got_reg == want_reg)
                begin
                    count_next = got_reg;
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else if (draws_reg == egsb_pkg::DRAW_LIMIT)
                begin
                    fill_next  = '0;
                    state_next = ST_FILL;
                end
                else
                begin
                    lfsr_next  = lfsr_adv;
                    draws_next = draws_reg + 1'b1;
                    if (lfsr_adv[31:16] <= thresh_reg)
                    begin
                        state_next = ST_EXPLORE;
                    end
                    else
                    begin
                        cand_next  = best_reg;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_EXPLORE:
            begin
                lfsr_next     = lfsr_adv;
                div_req.start = 1'b1;
                state_next    = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    cand_next  = div_rsp.remainder[egsb_pkg::ARM_W-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!hit)
                begin
                    chosen_we = 1'b1;
                    got_next  = got_reg + 1'b1;
                end
                state_next = ST_DRAW;
            end
            ST_FILL:
            begin
                if ((got_reg == want_reg) || (fill_reg == n_reg))
                begin
                    count_next = got_reg;
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    if (!hit)
                    begin
                        chosen_we = 1'b1;
                        got_next  = got_reg + 1'b1;
                    end
                    fill_next = fill_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_arm_next   = upd_arm;
                    out_last_next  = (idx_reg + 1'b1 == count_reg);
                    out_ack_next   = 1'b0;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_UPD_READ:
            begin
                state_next = ST_UPD_MUL;
            end
            ST_UPD_MUL:
            begin
                state_next = ST_UPD_START;
            end
            ST_UPD_START:
            begin
                upd_load         = 1'b1;
                div_req.start    = 1'b1;
                div_req.dividend = mag;
                div_req.divisor  = c_reg;
                state_next       = ST_UPD_DIV;
            end
            ST_UPD_DIV:
            begin
                if (div_rsp.done)
                begin
                    mem_we   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        state_next = ST_ACK;
                    end
                    else
                    begin
                        state_next = ST_UPD_READ;
                    end
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_arm_next   = '0;
                    out_last_next  = 1'b1;
                    out_ack_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we && (cfg_index == egsb_pkg::CFG_SEED))
        begin
            lfsr_next = (cfg_data == '0) ? 32'd1 : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            arm_count_reg <= egsb_pkg::ARM_COUNT_RST;
            thresh_reg    <= egsb_pkg::THRESH_RST;
            picks_reg     <= egsb_pkg::PICKS_RST;
            lfsr_reg      <= egsb_pkg::SEED_RST;
            got_reg       <= '0;
            draws_reg     <= '0;
            scan_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lfsr_reg      <= lfsr_next;
            got_reg       <= got_next;
            draws_reg     <= draws_next;
            scan_reg      <= scan_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
            begin
                vld_reg[upd_arm] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    egsb_pkg::CFG_ARM_COUNT: arm_count_reg <= cfg_data[egsb_pkg::ARM_CNT_W-1:0];
                    egsb_pkg::CFG_THRESHOLD: thresh_reg    <= cfg_data[15:0];
                    egsb_pkg::CFG_PICKS:     picks_reg     <= cfg_data[egsb_pkg::PICK_W-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        want_reg     <= want_next;
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
        cand_reg     <= cand_next;
        out_arm_reg  <= out_arm_next;
        out_last_reg <= out_last_next;
        out_ack_reg  <= out_ack_next;
        if ((state_reg == ST_IDLE) && item.valid)
        begin
            reward_reg <= item.reward;
        end
        if (state_reg == ST_UPD_MUL)
        begin
            prod_reg <= mean_eff * $signed({1'b0, c_new - 1'b1});
            c_reg    <= c_new;
        end
        if (upd_load)
        begin
            neg_reg <= num[48];
        end
        if (chosen_we)
        begin
            chosen_reg[got_reg[egsb_pkg::PICK_IDX_W-1:0]] <= chosen_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_mean_reg  <= mean_mem[rd_addr];
        rd_pulls_reg <= pulls_mem[rd_addr];
        rd_vld_reg   <= vld_reg[rd_addr];
        if (mem_we)
        begin
            mean_mem[upd_arm]  <= mean_wd;
            pulls_mem[upd_arm] <= c_reg;
        end
    end

    assign item.ready    = (state_reg == ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.arm    = out_arm_reg;
    assign result.last   = out_last_reg;
    assign result.is_ack = out_ack_reg;

`ifndef SYNTHESIS
    a_got_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_ACK && state_reg != ST_UPD_READ
         && state_reg != ST_UPD_MUL && state_reg != ST_UPD_START
         && state_reg != ST_UPD_DIV) |-> (got_reg <= want_reg))
        else $error("more arms chosen than wanted");
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("random generator reached zero");
    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_MOD_WAIT || state_reg == ST_UPD_DIV))
        else $error("divider finished outside a waiting state");
`endif

endmodule

[dv/egsb_checker.sv]
// Prediction and checking of the bandit's result words against its input words.
module egsb_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [egsb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [egsb_pkg::CFG_DATA_W-1:0] cfg_data,
    egsb_in_if                              item,
    egsb_out_if                             result,
    output int                              fails,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [egsb_pkg::ARM_W-1:0] arm;
        logic                       last;
        logic                       is_ack;
    } word_t;

    logic [egsb_pkg::ARM_CNT_W-1:0] arm_count;
    logic [15:0]                    threshold;
    logic [egsb_pkg::PICK_W-1:0]    picks;
    logic [31:0]                    rng;
    logic signed [31:0]             mean [egsb_pkg::MAX_ARMS];
    logic [egsb_pkg::PULL_W-1:0]    pulls [egsb_pkg::MAX_ARMS];
    logic [egsb_pkg::ARM_W-1:0]     chosen [egsb_pkg::MAX_PICKS];
    int                             chosen_n;
    word_t                          due_words [$];

    assign pending = due_words.size();

    function automatic logic [31:0] rng_advance();
        rng = {1'b0, rng[31:1]} ^ (rng[0] ? egsb_pkg::LFSR_MASK : 32'd0);
        return rng;
    endfunction

    function automatic bit already_chosen(int a, int cnt);
        for (int i = 0; i < cnt; i++)
        begin
            if (chosen[i] == a)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void choose_arms();
        int    n;
        int    want;
        int    got;
        int    draws;
        int    a;
        word_t w;
        n = (arm_count < 1) ? 1 : (arm_count > egsb_pkg::MAX_ARMS) ? egsb_pkg::MAX_ARMS
                                                                     : int'(arm_count);
        want = (picks < 1) ? 1 : (picks > egsb_pkg::MAX_PICKS) ? egsb_pkg::MAX_PICKS
                                                                : int'(picks);
        if (want > n)
        begin
            want = n;
        end
        got = 0;
        draws = 0;
        while (got < want && draws < int'(egsb_pkg::DRAW_LIMIT))
        begin
            draws++;
            if ((rng_advance() >> 16) <= threshold)
            begin
                a = int'(rng_advance() % n);
            end
            else
            begin
                a = 0;
                for (int i = 1; i < n; i++)
                begin
                    if (mean[i] > mean[a])
                    begin
                        a = i;
                    end
                end
            end
            if (!already_chosen(a, got))
            begin
                chosen[got] = egsb_pkg::ARM_W'(a);
                got++;
            end
        end
        for (int i = 0; i < n && got < want; i++)
        begin
            if (!already_chosen(i, got))
            begin
                chosen[got] = egsb_pkg::ARM_W'(i);
                got++;
            end
        end
        chosen_n = got;
        for (int i = 0; i < got; i++)
        begin
            w.arm = chosen[i];
            w.last = (i + 1 == got);
            w.is_ack = 1'b0;
            due_words.push_back(w);
        end
    endfunction

    function automatic void apply_reward(logic signed [31:0] r);
        longint c;
        longint q;
        longint nm;
        word_t  w;
        for (int i = 0; i < chosen_n; i++)
        begin
            if (pulls[chosen[i]] != egsb_pkg::PULL_MAX)
            begin
                pulls[chosen[i]]++;
            end
            c = longint'(pulls[chosen[i]]);
            q = longint'(mean[chosen[i]]);
            nm = (q * (c - 1) + longint'(r)) / c;
            mean[chosen[i]] = nm[31:0];
        end
        w.arm = '0;
        w.last = 1'b1;
        w.is_ack = 1'b1;
        due_words.push_back(w);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        if (!rst_n)
        begin
            arm_count = egsb_pkg::ARM_COUNT_RST;
            threshold = egsb_pkg::THRESH_RST;
            picks = egsb_pkg::PICKS_RST;
            rng = egsb_pkg::SEED_RST;
            for (int i = 0; i < egsb_pkg::MAX_ARMS; i++)
            begin
                mean[i] = '0;
                pulls[i] = '0;
            end
            chosen_n = 0;
            due_words.delete();
            fails = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (egsb_pkg::cfg_idx_t'(cfg_index))
                    egsb_pkg::CFG_ARM_COUNT: arm_count = cfg_data[egsb_pkg::ARM_CNT_W-1:0];
                    egsb_pkg::CFG_THRESHOLD: threshold = cfg_data[15:0];
                    egsb_pkg::CFG_PICKS:     picks = cfg_data[egsb_pkg::PICK_W-1:0];
                    egsb_pkg::CFG_SEED:      rng = (cfg_data == 0) ? 32'd1 : cfg_data;
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("unexpected result word: arm %0d last %0b is_ack %0b",
                           result.arm, result.last, result.is_ack);
                    fails++;
                end
                else
                begin
                    w = due_words.pop_front();
                    if (result.arm !== w.arm)
                    begin
                        $error("arm: expected %0d, got %0d", w.arm, result.arm);
                        fails++;
                    end
                    if (result.last !== w.last)
                    begin
                        $error("last: expected %0b, got %0b", w.last, result.last);
                        fails++;
                    end
                    if (result.is_ack !== w.is_ack)
                    begin
                        $error("is_ack: expected %0b, got %0b", w.is_ack, result.is_ack);
                        fails++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                if (item.kind)
                begin
                    apply_reward(item.reward);
                end
                else
                begin
                    choose_arms();
                end
            end
        end
    end
endmodule

[dv/epsilon_greedy_subset_bandit_top_tb.sv]
// Testbench top: clock, reset, configuration, input words and verdict.
module epsilon_greedy_subset_bandit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [egsb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [egsb_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              fails;
    int                              pending;
    int                              send_gap;
    int                              recv_stall;

    egsb_in_if  in_ch ();
    egsb_out_if out_ch ();

    epsilon_greedy_subset_bandit_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_ch),
        .result    (out_ch)
    );

    egsb_checker chk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_ch),
        .result    (out_ch),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_word(logic k, logic [31:0] r);
        while ($urandom_range(99) < send_gap)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= k;
        in_ch.reward <= r;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] arms, logic [31:0] thr, logic [31:0] pk,
                              logic [31:0] seed);
        cfg_we <= 1'b1;
        cfg_index <= egsb_pkg::CFG_ARM_COUNT;
        cfg_data <= arms;
        @(posedge clk);
        cfg_index <= egsb_pkg::CFG_THRESHOLD;
        cfg_data <= thr;
        @(posedge clk);
        cfg_index <= egsb_pkg::CFG_PICKS;
        cfg_data <= pk;
        @(posedge clk);
        cfg_index <= egsb_pkg::CFG_SEED;
        cfg_data <= seed;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_reward();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0004_0000);
            3: return -$urandom_range(32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = 1'b0;
        in_ch.reward = '0;
        send_gap = 0;
        recv_stall = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // update with no selection yet, then defaults
        send_word(1'b1, 32'h0001_0000);
        send_word(1'b0, 32'hFFFF_FFFF);
        send_word(1'b1, 32'h7FFF_FFFF);
        send_word(1'b1, 32'h7FFF_FFFF);
        send_word(1'b0, 32'h0);
        send_word(1'b1, 32'h8000_0000);
        send_word(1'b0, 32'h0);
        drain();
        // clamps: zero arms, zero picks, zero seed, zero threshold (nearly pure exploit)
        set_config(32'd0, 32'd0, 32'd0, 32'd0);
        send_word(1'b0, 32'h0);
        send_word(1'b1, 32'hFFFF_0000);
        drain();
        // oversize arm and pick counts, pure explore
        set_config(32'd127, 32'd65535, 32'd31, 32'hFFFF_FFFF);
        send_word(1'b0, 32'h0);
        send_word(1'b1, 32'h0000_8000);
        send_word(1'b0, 32'h0);
        drain();
        // picks equal to arms, zero threshold (mostly exploit): stuck draws fill the rest
        set_config(32'd16, 32'd0, 32'd16, 32'd7);
        send_word(1'b0, 32'h0);
        send_word(1'b1, 32'h0002_0000);
        send_word(1'b0, 32'h0);
        drain();
        set_config(32'd1, 32'd13107, 32'd1, 32'd1);
        send_word(1'b0, 32'h0);
        send_word(1'b1, 32'h7FFF_FFFF);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_gap = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_gap = 58;
                    recv_stall = 0;
                end
                2:
                begin
                    send_gap = 0;
                    recv_stall = 58;
                end
                default:
                begin
                    send_gap = 30;
                    recv_stall = 30;
                end
            endcase
            set_config($urandom_range(127),
                       $urandom_range(3) == 0 ? 65535 : $urandom_range(65535),
                       $urandom_range(31), $urandom);
            for (int i = 0; i < 27; i++)
            begin
                if ($urandom_range(99) < 55)
                begin
                    send_word(1'b0, $urandom);
                end
                else
                begin
                    send_word(1'b1, pick_reward());
                end
            end
            drain();
        end

        if (fails == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/egsb_pkg.sv
rtl/core/egsb_if.sv
rtl/core/egsb_divider.sv
rtl/core/epsilon_greedy_subset_bandit_top.sv
dv/egsb_checker.sv
dv/epsilon_greedy_subset_bandit_top_tb.sv
